FILE: src/selectable_checksum_engine_unit_assert.svh
// Assertion macros shared by the checksum engine RTL.
// Included by the top level; no other dependencies.
`ifndef SELECTABLE_CHECKSUM_ENGINE_UNIT_ASSERT_SVH
`define SELECTABLE_CHECKSUM_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define SCE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("checksum engine check failed");
// checked on every edge, reset included
`define SCE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("checksum engine check failed");
`else
`define SCE_ASSERT(label, prop)
`define SCE_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: src/sce_pkg.sv
// Shared types, constants and byte-update functions of the checksum engine.
// No dependencies; used by every module of the block.
package sce_pkg;

    // checksum selector codes
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SUM   = 2'd1,
        KIND_CRC16 = 2'd2,
        KIND_CRC32 = 2'd3
    } kind_t;

    // work codes handed from the front to the back
    typedef enum logic [1:0] {
        OP_ABSORB      = 2'd0,
        OP_ABSORB_LAST = 2'd1,
        OP_CLOSE       = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } queue_entry_t;

    // configuration write toward the back
    typedef struct packed {
        logic  en;
        kind_t kind;
    } cfg_wr_t;

    localparam int          QUEUE_DEPTH       = 2;
    localparam logic        REG_CHECKSUM_KIND = 1'b0;
    localparam logic [15:0] CRC16_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY        = 16'h1021;
    localparam logic [31:0] CRC32_INIT        = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC32_POLY        = 32'hEDB8_8320;

    function automatic logic [31:0] init_value(kind_t kind);
        logic [31:0] v;
        case (kind)
            KIND_CRC16: v = {16'h0000, CRC16_INIT};
            KIND_CRC32: v = CRC32_INIT;
            default:    v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // CRC-16 MSB first, eight shifts unrolled
    function automatic logic [15:0] crc16_byte(logic [15:0] acc, logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // reflected CRC-32, eight shifts unrolled
    function automatic logic [31:0] crc32_byte(logic [31:0] acc, logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] absorb_byte(kind_t kind, logic [31:0] acc,
                                                logic [7:0] b);
        logic [31:0] v;
        case (kind)
            KIND_SUM:   v = {16'h0000, acc[15:0] + {8'h00, b}};
            KIND_CRC16: v = {16'h0000, crc16_byte(acc[15:0], b)};
            KIND_CRC32: v = crc32_byte(acc, b);
            default:    v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] finish_value(kind_t kind, logic [31:0] acc);
        logic [31:0] v;
        case (kind)
            KIND_SUM, KIND_CRC16: v = {16'h0000, acc[15:0]};
            KIND_CRC32:           v = ~acc;
            default:              v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

FILE: src/sce_front.sv
// Front end: accepts input beats and classifies them into queue work codes.
// Depends on sce_pkg.
module sce_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,     // [7:0] data_byte
    input  logic                  s_tuser,     // [0] byte_present
    input  logic                  s_tlast,     // last_item
    input  logic                  q_full,
    output logic                  push,
    output sce_pkg::queue_entry_t push_entry
);

    // a beat is taken whenever the queue has room
    assign s_tready = !q_full;

    // classify: byte only, byte that closes, close without byte;
    // a beat with neither byte nor last is dropped here
    always_comb
    begin
        push_entry.data = s_tdata;
        if (s_tuser && s_tlast)
        begin
            push_entry.op = sce_pkg::OP_ABSORB_LAST;
        end
        else if (s_tuser)
        begin
            push_entry.op = sce_pkg::OP_ABSORB;
        end
        else
        begin
            push_entry.op = sce_pkg::OP_CLOSE;
        end
        push = s_tvalid && !q_full && (s_tuser || s_tlast);
    end

endmodule

FILE: src/sce_queue.sv
// Short FIFO of work entries between the front and back ends.
// Depends on sce_pkg.
module sce_queue #(
    parameter int DEPTH = sce_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sce_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output sce_pkg::queue_entry_t head,
    output logic                  head_valid,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sce_pkg::queue_entry_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/sce_back.sv
// Back end: running checksum accumulator and registered result stage.
// Depends on sce_pkg.
module sce_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sce_pkg::kind_t        kind,
    input  sce_pkg::cfg_wr_t      cfg_wr,
    input  sce_pkg::queue_entry_t head,
    input  logic                  head_valid,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata      // [31:0] checksum_value
);

    logic [31:0] running_reg, running_next;
    logic [31:0] result_reg, result_next;
    logic        valid_reg, valid_next;
    logic [31:0] acc_new;
    logic        closes;

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg;

    // closing entries need room in the result stage, plain bytes never wait
    assign closes = (head.op == sce_pkg::OP_ABSORB_LAST) || (head.op == sce_pkg::OP_CLOSE);
    assign pop    = head_valid && (!closes || !valid_reg || m_tready);

    always_comb
    begin
        case (head.op)
            sce_pkg::OP_ABSORB, sce_pkg::OP_ABSORB_LAST:
                acc_new = sce_pkg::absorb_byte(kind, running_reg, head.data);
            default:
                acc_new = running_reg;
        endcase

        running_next = running_reg;
        result_next  = result_reg;
        valid_next   = valid_reg && !m_tready;
        if (pop)
        begin
            if (closes)
            begin
                result_next  = sce_pkg::finish_value(kind, acc_new);
                valid_next   = 1'b1;
                running_next = sce_pkg::init_value(kind);
            end
            else
            begin
                running_next = acc_new;
            end
        end
        // a kind write reloads the accumulator
        if (cfg_wr.en)
        begin
            running_next = sce_pkg::init_value(cfg_wr.kind);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 32'h0000_0000;
            valid_reg   <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

FILE: src/selectable_checksum_engine_unit.sv
// Top level of the selectable checksum engine: APB register, front, queue, back.
// Depends on sce_pkg, sce_front, sce_queue, sce_back and the assertion header.
//
// Usage: message bytes enter on the s_ stream, one per beat; s_tuser marks a
// beat that carries a byte, s_tlast ends the message. The checksum of each
// message leaves on the m_ stream as one 32-bit beat (16-bit kinds are
// zero-extended). A beat with neither byte nor last gives no result.
// The APB register at address 0 selects the kind (0 none, 1 byte sum,
// 2 CRC-16/CCITT-FALSE, 3 CRC-32); a write reloads the accumulator.
// Write it only while no message is in flight.
// Timing: a closing beat is registered in the queue, then its result in the
// output register that drives m_tvalid. Throughput: one beat per cycle
// when the queue has room, set by the back end's combinational byte update.
// The front and back are parted by a QUEUE_DEPTH-entry queue; s_tready
// drops only when that queue is full. A stalled result is held in the output
// register while byte-only beats keep flowing into the accumulator.
// Reset clears the kind to none, the accumulator, the queue and m_tvalid.
`include "selectable_checksum_engine_unit_assert.svh"
module selectable_checksum_engine_unit #(
    parameter int QUEUE_DEPTH = sce_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] byte_present
    input  logic        s_tlast,    // last_item
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] checksum_value
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sce_pkg::kind_t        kind_reg, kind_next;
    sce_pkg::cfg_wr_t      cfg_wr;
    sce_pkg::queue_entry_t push_entry;
    sce_pkg::queue_entry_t head;
    logic                  push;
    logic                  pop;
    logic                  head_valid;
    logic                  q_full;
    logic                  reg_hit;

    // register decode
    assign pready      = 1'b1;
    assign reg_hit     = (paddr[2] == sce_pkg::REG_CHECKSUM_KIND);
    assign cfg_wr.en   = psel && penable && pwrite && pready && reg_hit;
    assign cfg_wr.kind = sce_pkg::kind_t'(pwdata[1:0]);
    assign prdata      = reg_hit ? {30'h0, kind_reg} : 32'h0000_0000;

    always_comb
    begin
        kind_next = cfg_wr.en ? cfg_wr.kind : kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= sce_pkg::KIND_NONE;
        end
        else
        begin
            kind_reg <= kind_next;
        end
    end

    sce_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    sce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    sce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind_reg),
        .cfg_wr     (cfg_wr),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // checks
    `SCE_ASSERT(a_no_push_when_full, push |-> !q_full)
    `SCE_ASSERT(a_no_pop_when_empty, pop |-> head_valid)
    `SCE_ASSERT(a_close_needs_room, (pop && head.op != sce_pkg::OP_ABSORB) |-> (!m_tvalid || m_tready))
    `SCE_ASSERT(a_kind_written, cfg_wr.en |=> (kind_reg == $past(cfg_wr.kind)))
    `SCE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid)

endmodule

FILE: sim/selectable_checksum_engine_unit_tb.sv
// Self-checking bench for the selectable checksum engine: directed beats, then random messages
// under several idle/stall mixes, checked against an in-bench checksum predictor.
// Depends on sce_pkg and selectable_checksum_engine_unit.
module selectable_checksum_engine_unit_tb;

    localparam logic [2:0]  ADDR_CHECKSUM_KIND = 3'd0;
    localparam logic [2:0]  ADDR_UNMAPPED      = 3'd4;
    localparam logic [15:0] SUM_SEED           = 16'h0000;
    localparam logic [15:0] CCITT_SEED         = 16'hFFFF;
    localparam logic [15:0] CCITT_POLY         = 16'h1021;
    localparam logic [31:0] ETH_SEED           = 32'hFFFF_FFFF;
    localparam logic [31:0] ETH_POLY_REFLECTED = 32'hEDB8_8320;
    localparam int          SETTLE_CYCLES      = 8;
    localparam int          CYCLE_LIMIT        = 400000;
    localparam int          BEATS_PER_PHASE    = 12;
    localparam int          LONG_SUM_BYTES     = 260;

    // Tracks the selected kind and running checksum, holds the sums still to come out.
    class checksum_predictor;
        sce_pkg::kind_t kind;
        logic [31:0]    running;
        logic [31:0]    pending_sums[$];
        int             errors;

        function new();
            kind    = sce_pkg::KIND_NONE;
            running = 32'h0;
            errors  = 0;
        endfunction

        function logic [31:0] seed_of(sce_pkg::kind_t k);
            case (k)
                sce_pkg::KIND_SUM:   return {16'h0, SUM_SEED};
                sce_pkg::KIND_CRC16: return {16'h0, CCITT_SEED};
                sce_pkg::KIND_CRC32: return ETH_SEED;
                default:             return 32'h0;
            endcase
        endfunction

        // bit-serial form of each byte update
        function logic [31:0] fold_byte(sce_pkg::kind_t k, logic [31:0] acc, logic [7:0] b);
            logic [15:0] c16;
            logic [31:0] c32;
            logic        fb;
            c16 = acc[15:0];
            c32 = acc;
            case (k)
                sce_pkg::KIND_SUM:
                    return {16'h0, acc[15:0] + {8'h0, b}};
                sce_pkg::KIND_CRC16:
                begin
                    for (int i = 7; i >= 0; i--)
                    begin
                        fb  = c16[15] ^ b[i];
                        c16 = {c16[14:0], 1'b0};
                        if (fb)
                            c16 = c16 ^ CCITT_POLY;
                    end
                    return {16'h0, c16};
                end
                sce_pkg::KIND_CRC32:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        fb  = c32[0] ^ b[i];
                        c32 = c32 >> 1;
                        if (fb)
                            c32 = c32 ^ ETH_POLY_REFLECTED;
                    end
                    return c32;
                end
                default:
                    return 32'h0;
            endcase
        endfunction

        function logic [31:0] final_sum(sce_pkg::kind_t k, logic [31:0] acc);
            case (k)
                sce_pkg::KIND_SUM, sce_pkg::KIND_CRC16: return {16'h0, acc[15:0]};
                sce_pkg::KIND_CRC32:                    return ~acc;
                default:                                return 32'h0;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %0s", $time, msg);
        endtask

        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_CHECKSUM_KIND)
            begin
                kind    = sce_pkg::kind_t'(value[1:0]);
                running = seed_of(kind);
            end
        endfunction

        function void note_beat(logic [7:0] b, logic present, logic last);
            if (present)
                running = fold_byte(kind, running, b);
            if (last)
            begin
                pending_sums.push_back(final_sum(kind, running));
                running = seed_of(kind);
            end
        endfunction

        task check_sum(logic [31:0] got);
            logic [31:0] want;
            if (pending_sums.size() == 0)
                report($sformatf("checksum %08h with none expected", got));
            else
            begin
                want = pending_sums.pop_front();
                if (got !== want)
                    report($sformatf("checksum_value %08h, expected %08h", got, want));
            end
        endtask

        task check_readback(logic [31:0] got);
            if (got !== {30'h0, kind})
                report($sformatf("checksum_kind read %08h, expected %0d", got, kind));
        endtask

        function int outstanding();
            return pending_sums.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] byte_present
    logic        s_tlast = 1'b0;    // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] checksum_value
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    checksum_predictor sums = new();

    selectable_checksum_engine_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("selectable_checksum_engine_unit_tb: done, errors");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor: register access, accepted input beats, accepted result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                    sums.write_reg(paddr, pwdata);
                else if (paddr == ADDR_CHECKSUM_KIND)
                    sums.check_readback(prdata);
            end
            if (s_tvalid && s_tready)
                sums.note_beat(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                sums.check_sum(m_tdata);
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // one input beat; returns at the edge it is taken, tvalid left high
    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending, wait for every expected checksum, then let the queue settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sums.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // kind write with junk in the upper bits, then read back
    task automatic select_kind(input sce_pkg::kind_t k);
        apb_access(1'b1, ADDR_CHECKSUM_KIND, {$urandom() & 32'hFFFF_FFFC} | {30'h0, k});
        apb_access(1'b0, ADDR_CHECKSUM_KIND, $urandom());
    endtask

    // random messages with noise beats and bare closes mixed in
    task automatic random_messages(input int beats);
        int  sent;
        int  len;
        int  pick;
        logic bare_close;
        sent = 0;
        while (sent < beats)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = 0;
            else if (pick < 90)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 24);
            bare_close = (len == 0) || ($urandom_range(2) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !bare_close);
                sent++;
            end
            if (bare_close)
            begin
                send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    initial
    begin
        sce_pkg::kind_t phase_kind[8];
        phase_kind = '{sce_pkg::KIND_SUM, sce_pkg::KIND_CRC32,
                       sce_pkg::KIND_NONE, sce_pkg::KIND_CRC16,
                       sce_pkg::KIND_CRC32, sce_pkg::KIND_SUM,
                       sce_pkg::KIND_CRC16, sce_pkg::KIND_NONE};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        set_idling(0);

        // kind none after reset: byte message and empty message
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        drain();

        // byte sum: empty, extremes, ignored beat inside
        select_kind(sce_pkg::KIND_SUM);
        send_beat(8'hFF, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b0, 1'b0);
        send_beat(8'h01, 1'b1, 1'b1);
        drain();

        // crc16 check string, then empty message
        select_kind(sce_pkg::KIND_CRC16);
        for (int i = 0; i < 9; i++)
            send_beat(8'(8'h31 + i), 1'b1, i == 8);
        send_beat(8'h55, 1'b0, 1'b1);
        drain();

        // crc32: bare close after bytes, empty message
        select_kind(sce_pkg::KIND_CRC32);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
        drain();

        // kind changed mid-message drops the partial bytes; unmapped write does nothing
        send_beat(8'hA5, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b1, 1'b0);
        drain();
        select_kind(sce_pkg::KIND_CRC16);
        send_beat(8'h31, 1'b1, 1'b0);
        drain();
        apb_access(1'b1, ADDR_UNMAPPED, 32'hFFFF_FFFF);
        send_beat(8'h32, 1'b1, 1'b1);
        drain();

        // random phases over every kind and idling mix
        for (int p = 0; p < 8; p++)
        begin
            select_kind(phase_kind[p]);
            set_idling(p % 4);
            random_messages(BEATS_PER_PHASE);
            // one message long enough to wrap the 16-bit byte sum
            if (p == 5)
            begin
                for (int i = 0; i < LONG_SUM_BYTES; i++)
                    send_beat(8'hFF, 1'b1, i == LONG_SUM_BYTES - 1);
            end
            drain();
        end

        if (sums.errors == 0)
            $display("selectable_checksum_engine_unit_tb: done, clean");
        else
            $display("selectable_checksum_engine_unit_tb: done, errors");
        $finish;
    end
endmodule
